@@ sv/csr_sparse_matvec_unit_assert.svh @@
// ----------------------------------------------------------------------------
// CSR sparse matvec assertion macros
// Clocked property checks for the sparse matvec unit; compiled out when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATVEC_UNIT_ASSERT_SVH
`define CSR_SPARSE_MATVEC_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset
`define CSRMV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define CSRMV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CSRMV_ASSERT(lbl, clk, rst, prop, msg)
`define CSRMV_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ sv/csrmv_pkg.sv @@
// ----------------------------------------------------------------------------
// CSR sparse matvec package
// Word types, command codes, Q16.16 constants and shared helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csrmv_pkg;

  // Default geometry
  localparam int DEF_ROWS    = 64;
  localparam int DEF_ENTRIES = 1024;

  // Field widths
  localparam int CMD_W = 3;
  localparam int ROW_W = 7;
  localparam int COL_W = 6;
  localparam int PTR_W = 11;
  localparam int VAL_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * VAL_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SET_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_ENTRY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_VEC   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROW       = 3'd4;

  // Q16.16 limits
  localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic [PTR_W-1:0]        entry;
    logic signed [VAL_W-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [COL_W-1:0]        out_row;
    logic signed [VAL_W-1:0] product;
    logic                    saturated;
  } result_word_t;

  // Control from the sequencer to the multiply-accumulate path
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

  // Status back from the multiply-accumulate path
  typedef struct packed {
    logic busy;
  } mac_sts_t;

  // Add two Q16.16 values, clip to the 32-bit range
  function automatic logic [VAL_W-1:0] sat_add32(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
    logic [VAL_W:0] sum;
    sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      return sum[VAL_W] ? Q_MIN : Q_MAX;
    end
    return sum[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/csrmv_ram.sv @@
// ----------------------------------------------------------------------------
// CSR sparse matvec RAM
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csrmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/csrmv_mac.sv @@
// ----------------------------------------------------------------------------
// CSR sparse matvec multiply-accumulate
// Registered 32x32 multiply, full-width running sum, Q16.16 saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csrmv_mac #(
  parameter int ENTRIES = csrmv_pkg::DEF_ENTRIES
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire csrmv_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [csrmv_pkg::VAL_W-1:0]  mult_a,
  input  wire logic signed [csrmv_pkg::VAL_W-1:0]  mult_b,
  output csrmv_pkg::mac_sts_t                      sts,
  output logic signed [csrmv_pkg::VAL_W-1:0]       product,
  output logic                                     saturated
);

  import csrmv_pkg::*;

  // Sum of up to ENTRIES full products without overflow
  localparam int ACC_W = PROD_W + $clog2(ENTRIES + 1);
  // Highest bit kept by the Q16.16 result
  localparam int TOP_B = VAL_W + FRAC_W - 1;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_v;
  logic signed [ACC_W-1:0]  acc;
  logic                     ovf;

  // Register the product, then add it in
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.valid & ~ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mult_a * mult_b;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Clip when the bits above the kept window are not a plain sign extension
  assign ovf = !((&acc[ACC_W-1:TOP_B]) || !(|acc[ACC_W-1:TOP_B]));

  always_comb begin
    if (ovf) begin
      product = acc[ACC_W-1] ? Q_MIN : Q_MAX;
    end else begin
      product = acc[TOP_B:FRAC_W];
    end
  end

  assign saturated = ovf;
  assign sts.busy  = prod_v;

endmodule

`default_nettype wire

@@ sv/csr_sparse_matvec_unit.sv @@
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector unit
// Holds a CSR sparse matrix and a dense vector in RAM; updates entries and
// computes single-row dot products in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage: drive a word on item with start high; it is taken when busy is low.
// Set-row-start, set-entry and set-vector words are written in the accept
// cycle and keep busy low. An add word reads its two row pointers, then walks
// the row in entry RAM, one entry per cycle, until an entry matches the word's
// column or the row ends. A compute-row word reads the two row pointers on the
// pointer/vector RAM port, then streams the row's entries one per cycle
// through entry read, vector read, multiply and accumulate; busy stays high
// while the row is walked and drained, so the row length sets the time per
// word. The result appears on result for exactly one cycle with done high, the
// first cycle with busy low again, and a new word may be taken in that same
// cycle; the receiver cannot stall it, so capture it in that cycle. Add and
// compute-row words for rows at or beyond ROWS, set words out of range and
// unknown commands are taken and dropped. Store contents are undefined until
// written; nothing is cleared at reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "csr_sparse_matvec_unit_assert.svh"

module csr_sparse_matvec_unit #(
  parameter int ROWS    = csrmv_pkg::DEF_ROWS,
  parameter int ENTRIES = csrmv_pkg::DEF_ENTRIES
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire csrmv_pkg::cmd_word_t    item,
  output logic                         done,
  output csrmv_pkg::result_word_t      result
);

  import csrmv_pkg::*;

  // Entry RAM: {column, value}
  localparam int ENT_DW = COL_W + VAL_W;
  localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Pointer/vector RAM: row starts at 0..ROWS, vector at ROWS+1..2*ROWS
  localparam int PV_DEPTH = 2 * ROWS + 1;
  localparam int BW       = $clog2(PV_DEPTH);
  localparam logic [BW-1:0] VEC_BASE = BW'(ROWS + 1);
  // Walk pointer covers the stored pointer range and ENTRIES itself
  localparam int PW = ($clog2(ENTRIES + 1) > PTR_W) ? $clog2(ENTRIES + 1) : PTR_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BEGIN = 3'd1;
  localparam logic [2:0] S_END   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]          state;
  cmd_word_t           item_q;
  logic [PW-1:0]       ptr;
  logic [PW-1:0]       limit;
  logic [PW-1:0]       row_end;
  logic                v1;
  logic                v2;
  logic [EW-1:0]       addr1;
  logic signed [VAL_W-1:0] val2;
  logic                col_ok2;

  logic                accept;
  logic                walk_cmd;
  logic                is_row_q;
  logic                issue;
  logic                wb_we;
  logic                walk_empty;

  logic                a_we;
  logic [EW-1:0]       a_waddr;
  logic [ENT_DW-1:0]   a_wdata;
  logic [ENT_DW-1:0]   a_rdata;
  logic [COL_W-1:0]    a_col;
  logic [VAL_W-1:0]    a_val;

  logic                b_we;
  logic [BW-1:0]       b_waddr;
  logic [VAL_W-1:0]    b_wdata;
  logic [BW-1:0]       b_raddr;
  logic [VAL_W-1:0]    b_rdata;

  mac_ctl_t            mac_ctl;
  mac_sts_t            mac_sts;
  logic signed [VAL_W-1:0] mac_b;
  logic signed [VAL_W-1:0] mac_product;
  logic                mac_sat;

  assign busy   = (state != S_IDLE);
  assign accept = start & ~busy;

  // Decode words that need a row walk
  assign walk_cmd = ((item.cmd == CMD_ADD) || (item.cmd == CMD_ROW)) &&
                    (32'(item.row) < ROWS);
  assign is_row_q = (item_q.cmd == CMD_ROW);

  assign a_col = a_rdata[ENT_DW-1:VAL_W];
  assign a_val = a_rdata[VAL_W-1:0];

  // Write back the first matching entry of an add; stop the walk there
  assign wb_we = (state == S_WALK) && v1 && (item_q.cmd == CMD_ADD) &&
                 (a_col == item_q.col);
  assign issue = (state == S_WALK) && (ptr < limit) && !wb_we;
  assign walk_empty = (ptr >= limit) && !v1;

  // Clip the row end to the entry store
  assign row_end = (PW'(b_rdata[PTR_W-1:0]) > PW'(ENTRIES)) ?
                   PW'(ENTRIES) : PW'(b_rdata[PTR_W-1:0]);

  // Entry RAM port control
  always_comb begin
    a_we    = wb_we || (accept && (item.cmd == CMD_SET_ENTRY) &&
                        (32'(item.entry) < ENTRIES));
    a_waddr = wb_we ? addr1 : EW'(item.entry);
    a_wdata = wb_we ? {a_col, sat_add32(a_val, item_q.value)} :
                      {item.col, item.value};
  end

  // Pointer/vector RAM port control
  always_comb begin
    b_we    = accept && (((item.cmd == CMD_SET_START) && (32'(item.row) <= ROWS)) ||
                         ((item.cmd == CMD_SET_VEC) && (32'(item.col) < ROWS)));
    b_waddr = (item.cmd == CMD_SET_START) ? BW'(item.row) : VEC_BASE + BW'(item.col);
    b_wdata = (item.cmd == CMD_SET_START) ? VAL_W'(item.entry) : item.value;
    unique case (state)
      S_IDLE:  b_raddr = BW'(item.row);
      S_BEGIN: b_raddr = BW'(item_q.row) + BW'(1);
      default: b_raddr = VEC_BASE + BW'(a_col);
    endcase
  end

  csrmv_ram #(
    .WIDTH (ENT_DW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (ptr[EW-1:0]),
    .rdata (a_rdata)
  );

  csrmv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (PV_DEPTH)
  ) u_ptr_vec_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Feed the multiplier; a column beyond the vector reads as zero
  assign mac_ctl.clear = (state == S_END);
  assign mac_ctl.valid = v2;
  assign mac_b         = col_ok2 ? b_rdata : '0;

  csrmv_mac #(
    .ENTRIES (ENTRIES)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .mult_a    (val2),
    .mult_b    (mac_b),
    .sts       (mac_sts),
    .product   (mac_product),
    .saturated (mac_sat)
  );

  // Sequence one word at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      v1   <= issue;
      v2   <= v1 & is_row_q;
      unique case (state)
        S_IDLE: begin
          if (accept && walk_cmd) begin
            state <= S_BEGIN;
          end
        end
        S_BEGIN: state <= S_END;
        S_END:   state <= S_WALK;
        S_WALK: begin
          if (!is_row_q) begin
            if (wb_we || walk_empty) begin
              state <= S_IDLE;
            end
          end else if (walk_empty && !v2 && !mac_sts.busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the word, walk pointers and pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (state == S_BEGIN) begin
      ptr <= PW'(b_rdata[PTR_W-1:0]);
    end else if (issue) begin
      ptr <= ptr + PW'(1);
    end
    if (state == S_END) begin
      limit <= row_end;
    end
    if (issue) begin
      addr1 <= ptr[EW-1:0];
    end
    if (v1) begin
      val2    <= a_val;
      col_ok2 <= (32'(a_col) < ROWS);
    end
    if (state == S_FIN) begin
      result.out_row   <= item_q.row[COL_W-1:0];
      result.product   <= mac_product;
      result.saturated <= mac_sat;
    end
  end

  // Checks
  `CSRMV_ASSERT(a_done_after_fin, clk, rst,
                done |-> ($past(state) == S_FIN), "result strobe without finish state")
  `CSRMV_ASSERT(a_wb_only_add, clk, rst,
                (wb_we) |-> (item_q.cmd == CMD_ADD) && !b_we,
                "entry write-back outside an add")
  `CSRMV_ASSERT(a_ptr_in_range, clk, rst,
                (state == S_WALK && issue) |-> (ptr < PW'(ENTRIES)),
                "entry read beyond the store")
  `CSRMV_ASSERT(a_fin_drained, clk, rst,
                (state == S_FIN) |-> (!v1 && !v2 && !mac_sts.busy),
                "finish with products in flight")
  `CSRMV_ASSERT_ALWAYS(a_no_accept_busy, clk,
                       (rst) |=> (!busy && !done), "busy or done out of reset")

endmodule

`default_nettype wire
